// ----- sv/apts_pkg.sv -----
// package for the aging priority tick scheduler
// fixed field widths, register indexes, function and sequencer state codes and a saturating add; no dependencies
package apts_pkg;

  localparam int ID_W    = 4;
  localparam int BURST_W = 8;
  localparam int PRIO_W  = 16;
  localparam int ORDER_W = 16;
  localparam int WAIT_W  = 16;
  localparam int GAIN_W  = 8;
  localparam int CIDX_W  = 8;

  localparam logic [CIDX_W-1:0] REG_RUN_GAIN  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_WAIT_GAIN = 8'd1;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ASCAN = 4'b0010,
    ST_TSCAN = 4'b0100,
    ST_TFIN  = 4'b1000
  } state_t;

  function automatic logic [PRIO_W-1:0] sat_add(input logic [PRIO_W-1:0] a,
                                                input logic [GAIN_W-1:0] b);
    logic [PRIO_W:0] s;
    s = {1'b0, a} + {{(PRIO_W + 1 - GAIN_W){1'b0}}, b};
    sat_add = s[PRIO_W] ? {PRIO_W{1'b1}} : s[PRIO_W-1:0];
  endfunction

endpackage

// ----- sv/aging_priority_tick_scheduler.sv -----
// aging priority tick scheduler, top level
// slot table in a memory with registered read data, uses apts_pkg
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tuser: func; tdata: proc_id, burst_len
// out_     out  out_tvalid/out_tready tuser: ran_valid; tdata: ran_id .. overflow
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// an arrival with a nonzero burst walks the valid bits one slot a cycle
// until it takes the lowest free slot, or sets overflow when the table is full
// a tick streams every slot through the memory read port and ages each valid
// slot on the write port, then writes the winner back as the result is loaded;
// the next input is taken once the sequencer is back in idle
// the end of a tick waits while the previous result has not been taken
// rst_n is synchronous; valid bits and counters clear, table contents do not
module aging_priority_tick_scheduler
  import apts_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // proc_id[3:0], burst_len[11:4], zero pad
  input  logic              in_tuser,   // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // ran_id[3:0], finished[4], wait_time[20:5],
                                        // overflow[21], zero pad
  output logic              out_tuser,  // ran_valid
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam int TB = TIME_BITS;

  // slot table storage
  logic [ID_W-1:0]    mem_ident [SLOTS];
  logic [BURST_W-1:0] mem_rem   [SLOTS];
  logic [BURST_W-1:0] mem_total [SLOTS];
  logic [TB-1:0]      mem_arr   [SLOTS];
  logic [PRIO_W-1:0]  mem_prio  [SLOTS];
  logic [TB-1:0]      mem_last  [SLOTS];
  logic [ORDER_W-1:0] mem_order [SLOTS];

  // registered read data
  logic [ID_W-1:0]    q_ident;
  logic [BURST_W-1:0] q_rem, q_total;
  logic [TB-1:0]      q_arr, q_last;
  logic [PRIO_W-1:0]  q_prio;
  logic [ORDER_W-1:0] q_order;

  // write port
  logic               we;
  logic [IW-1:0]      w_addr;
  logic [ID_W-1:0]    w_ident;
  logic [BURST_W-1:0] w_rem, w_total;
  logic [TB-1:0]      w_arr, w_last;
  logic [PRIO_W-1:0]  w_prio;
  logic [ORDER_W-1:0] w_order;
  logic [IW-1:0]      r_addr;

  // control state
  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_slot_r, rd_slot_nxt;
  logic [TB-1:0]      tick_r, tick_nxt;
  logic [ORDER_W-1:0] seq_r, seq_nxt;
  logic               ovf_r, ovf_nxt;
  logic [GAIN_W-1:0]  run_gain_r, run_gain_nxt, wait_gain_r, wait_gain_nxt;
  logic               has_best_r, has_best_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload registers
  logic [ID_W-1:0]    pid_r, pid_nxt;
  logic [BURST_W-1:0] pburst_r, pburst_nxt;
  logic [IW-1:0]      b_slot_r, b_slot_nxt;
  logic [ID_W-1:0]    b_ident_r, b_ident_nxt;
  logic [BURST_W-1:0] b_rem_r, b_rem_nxt, b_total_r, b_total_nxt;
  logic [TB-1:0]      b_arr_r, b_arr_nxt, b_last_r, b_last_nxt;
  logic [PRIO_W-1:0]  b_prio_r, b_prio_nxt;
  logic [ORDER_W-1:0] b_order_r, b_order_nxt;
  logic [23:0]        out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  logic               beats;
  logic               out_free;
  logic [BURST_W-1:0] rem_dec;
  logic               fin;
  logic [TB-1:0]      wait_full;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_ident[w_addr] <= w_ident;
      mem_rem[w_addr]   <= w_rem;
      mem_total[w_addr] <= w_total;
      mem_arr[w_addr]   <= w_arr;
      mem_prio[w_addr]  <= w_prio;
      mem_last[w_addr]  <= w_last;
      mem_order[w_addr] <= w_order;
    end
    q_ident <= mem_ident[r_addr];
    q_rem   <= mem_rem[r_addr];
    q_total <= mem_total[r_addr];
    q_arr   <= mem_arr[r_addr];
    q_prio  <= mem_prio[r_addr];
    q_last  <= mem_last[r_addr];
    q_order <= mem_order[r_addr];
  end

  // candidate from the read port against the best so far
  always_comb begin
    if (!has_best_r) begin
      beats = 1'b1;
    end else if (q_prio != b_prio_r) begin
      beats = q_prio > b_prio_r;
    end else if (q_last != b_last_r) begin
      beats = q_last < b_last_r;
    end else begin
      beats = q_order < b_order_r;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign rem_dec   = b_rem_r - BURST_W'(1);
  assign fin       = has_best_r && (rem_dec == '0);
  assign wait_full = tick_r - b_arr_r - TB'(b_total_r) + TB'(1);
  assign r_addr    = cnt_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_slot_nxt   = rd_slot_r;
    tick_nxt      = tick_r;
    seq_nxt       = seq_r;
    ovf_nxt       = ovf_r;
    run_gain_nxt  = run_gain_r;
    wait_gain_nxt = wait_gain_r;
    has_best_nxt  = has_best_r;
    out_valid_nxt = out_valid_r && !out_tready;
    pid_nxt       = pid_r;
    pburst_nxt    = pburst_r;
    b_slot_nxt    = b_slot_r;
    b_ident_nxt   = b_ident_r;
    b_rem_nxt     = b_rem_r;
    b_total_nxt   = b_total_r;
    b_arr_nxt     = b_arr_r;
    b_last_nxt    = b_last_r;
    b_prio_nxt    = b_prio_r;
    b_order_nxt   = b_order_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    we            = 1'b0;
    w_addr        = cnt_r[IW-1:0];
    w_ident       = pid_r;
    w_rem         = pburst_r;
    w_total       = pburst_r;
    w_arr         = tick_r;
    w_prio        = '0;
    w_last        = '0;
    w_order       = seq_r;

    if (cfg_valid) begin
      if (cfg_index == REG_RUN_GAIN)  run_gain_nxt  = cfg_data;
      if (cfg_index == REG_WAIT_GAIN) wait_gain_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        cnt_nxt      = '0;
        has_best_nxt = 1'b0;
        if (in_tvalid) begin
          pid_nxt    = in_tdata[3:0];
          pburst_nxt = in_tdata[11:4];
          if (in_tuser == FUNC_TICK) begin
            state_nxt = ST_TSCAN;
          end else if (in_tdata[11:4] != '0) begin
            state_nxt = ST_ASCAN;
          end
        end
      end
      ST_ASCAN: begin
        // lowest free slot, one valid bit a cycle
        if (cnt_r == SLOTS_C) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!valid_r[cnt_r[IW-1:0]]) begin
          we                       = 1'b1;
          valid_nxt[cnt_r[IW-1:0]] = 1'b1;
          seq_nxt                  = seq_r + ORDER_W'(1);
          state_nxt                = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_TSCAN: begin
        if (cnt_r != SLOTS_C) begin
          rd_vld_nxt  = 1'b1;
          rd_slot_nxt = cnt_r[IW-1:0];
          cnt_nxt     = cnt_r + CW'(1);
        end
        if (rd_vld_r && valid_r[rd_slot_r]) begin
          // age in place; the winner is rewritten from the best registers
          we      = 1'b1;
          w_addr  = rd_slot_r;
          w_ident = q_ident;
          w_rem   = q_rem;
          w_total = q_total;
          w_arr   = q_arr;
          w_prio  = sat_add(q_prio, wait_gain_r);
          w_last  = q_last;
          w_order = q_order;
          if (beats) begin
            has_best_nxt = 1'b1;
            b_slot_nxt   = rd_slot_r;
            b_ident_nxt  = q_ident;
            b_rem_nxt    = q_rem;
            b_total_nxt  = q_total;
            b_arr_nxt    = q_arr;
            b_last_nxt   = q_last;
            b_prio_nxt   = q_prio;
            b_order_nxt  = q_order;
          end
        end
        if (cnt_r == SLOTS_C && !rd_vld_r) state_nxt = ST_TFIN;
      end
      ST_TFIN: begin
        if (out_free) begin
          if (has_best_r) begin
            we      = 1'b1;
            w_addr  = b_slot_r;
            w_ident = b_ident_r;
            w_rem   = rem_dec;
            w_total = b_total_r;
            w_arr   = b_arr_r;
            w_prio  = sat_add(b_prio_r, run_gain_r);
            w_last  = tick_r;
            w_order = b_order_r;
            if (fin) valid_nxt[b_slot_r] = 1'b0;
          end
          out_valid_nxt = 1'b1;
          out_user_nxt  = has_best_r;
          out_data_nxt  = {2'b00, ovf_r,
                           fin ? WAIT_W'(wait_full) : WAIT_W'(0),
                           fin,
                           has_best_r ? b_ident_r : ID_W'(0)};
          tick_nxt      = tick_r + TB'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      tick_r      <= '0;
      seq_r       <= '0;
      ovf_r       <= 1'b0;
      run_gain_r  <= GAIN_W'(1);
      wait_gain_r <= GAIN_W'(2);
      has_best_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      tick_r      <= tick_nxt;
      seq_r       <= seq_nxt;
      ovf_r       <= ovf_nxt;
      run_gain_r  <= run_gain_nxt;
      wait_gain_r <= wait_gain_nxt;
      has_best_r  <= has_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r  <= rd_slot_nxt;
    pid_r      <= pid_nxt;
    pburst_r   <= pburst_nxt;
    b_slot_r   <= b_slot_nxt;
    b_ident_r  <= b_ident_nxt;
    b_rem_r    <= b_rem_nxt;
    b_total_r  <= b_total_nxt;
    b_arr_r    <= b_arr_nxt;
    b_last_r   <= b_last_nxt;
    b_prio_r   <= b_prio_nxt;
    b_order_r  <= b_order_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_ready  = 1'b1;

  // a finished process was always served
  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tuser)
    else $error("finished without a served process");

  // a wait time is only reported for a finished process
  a_wait_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[20:5] != '0) |-> out_tdata[4])
    else $error("wait time without finish");

  // read data in flight only while scanning for a tick
  a_rd_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_TSCAN))
    else $error("read pipeline active outside tick scan");

  // the tick counter advances exactly when a tick result is loaded
  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TFIN) && out_free |=> (tick_r == $past(tick_r) + TB'(1)) && out_tvalid)
    else $error("tick counter did not advance with result");

  // an accepted tick starts the slot scan
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_TICK) |=> (state_r == ST_TSCAN))
    else $error("tick did not start scan");

endmodule
